FILE: rtl/mhpq_pkg.sv
package mhpq_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_READ_MAX = 2'd2,
      OP_READ_MIN = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_DUP   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UP_CMP,
      ST_ROOT,
      ST_EX_LAST,
      ST_DN_R,
      ST_DN_CMP,
      ST_MIN,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [DATA_W-1:0]  value_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  value_out;
      status_type                status;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

endpackage

FILE: rtl/mhpq_ram.sv
module mhpq_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [mhpq_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [mhpq_pkg::DATA_W-1:0] rd_data
);

   logic signed [mhpq_pkg::DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit values held in one single-port-read,
// single-port-write RAM of CAPACITY words (registered read). Each request
// transfer carries one operation: insert, extract maximum, read maximum or read
// minimum; each produces exactly one response transfer with the returned value, a
// status (ok, empty, full, duplicate) and the entry count after the operation. The
// block works on one request at a time, paced by the single RAM read port: insert
// first scans all entries for a duplicate, then lets the new value climb one level
// at a time; extract reads the root and the tail, then lets the moved entry sink one
// level at a time towards a leaf; read maximum reads the root; read minimum scans
// the leaves for the smallest value.
// A finished response sits in an output register, so the next request is taken
// while that response still waits for rsp_ready. No RAM clearing is needed after
// reset: only entries below the count are ever used.
module max_heap_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mhpq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mhpq_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;
   localparam int XW = (CW > mhpq_pkg::COUNT_W) ? CW : mhpq_pkg::COUNT_W;
   localparam int DW = mhpq_pkg::DATA_W;

   // control and datapath registers
   mhpq_pkg::state_type   state_ff, state_in;
   mhpq_pkg::op_type      op_ff, op_in;
   logic signed [DW-1:0]  val_ff, val_in;      // inserted value, or the hole value
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         ptr_ff, ptr_in;      // next scan address
   logic [AW-1:0]         pos_ff, pos_in;      // current hole position
   logic signed [DW-1:0]  lval_ff, lval_in;    // left child value
   logic                  rok_ff, rok_in;      // right child exists
   logic                  first_ff, first_in;
   logic signed [DW-1:0]  min_ff, min_in;
   logic signed [DW-1:0]  res_ff, res_in;
   mhpq_pkg::status_type  stat_ff, stat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::rsp_type     rsp_ff, rsp_in;

   // RAM port
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic signed [DW-1:0]  wr_data;
   logic [AW-1:0]         rd_addr;
   logic signed [DW-1:0]  rd_data;

   // shared decode
   logic                  req_fire;
   logic                  out_free;
   logic                  cnt_full;
   logic                  cnt_zero;
   logic                  cnt_one;
   logic                  scan_hit;
   logic                  scan_end;
   logic [AW-1:0]         pos_par;
   logic [AW-1:0]         pos_gpar;
   logic [AW-1:0]         cnt_par;
   logic                  up_move;
   logic [IW-1:0]         l_idx;
   logic [IW-1:0]         r_idx;
   logic                  l_ok;
   logic                  r_ok;
   logic signed [DW-1:0]  big_val;
   logic [AW-1:0]         big_idx;
   logic                  dn_move;
   logic [IW-1:0]         big_l;
   logic                  big_l_ok;
   logic signed [DW-1:0]  min_new;
   logic [XW-1:0]         cnt_x;

   mhpq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready   = (state_ff == mhpq_pkg::ST_IDLE);
   assign req_fire    = req_valid & req_ready;
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cnt_full = (count_ff == CW'(CAPACITY));
   assign cnt_zero = (count_ff == '0);
   assign cnt_one  = (count_ff == CW'(1));
   assign scan_hit = (rd_data == val_ff);
   assign scan_end = (ptr_ff == count_ff);

   // sift-up addressing: rd_data holds the parent of the hole
   assign pos_par  = AW'((pos_ff - AW'(1)) >> 1);
   assign pos_gpar = AW'((pos_par - AW'(1)) >> 1);
   assign cnt_par  = AW'((count_ff - CW'(1)) >> 1);
   assign up_move  = (rd_data < val_ff);

   // sift-down addressing: children of the hole and of the winning child
   assign l_idx = {1'b0, pos_ff, 1'b1};
   assign r_idx = l_idx + IW'(1);
   assign l_ok  = (l_idx < IW'(count_ff));
   assign r_ok  = (r_idx < IW'(count_ff));

   // pick the larger child; ties keep the left child, and the hole stays unless
   // a child is strictly larger
   always_comb begin
      big_val = val_ff;
      big_idx = pos_ff;
      if (lval_ff > val_ff) begin
         big_val = lval_ff;
         big_idx = l_idx[AW-1:0];
      end
      if (rok_ff && (rd_data > big_val)) begin
         big_val = rd_data;
         big_idx = r_idx[AW-1:0];
      end
   end

   assign dn_move  = (big_idx != pos_ff);
   assign big_l    = {1'b0, big_idx, 1'b1};
   assign big_l_ok = (big_l < IW'(count_ff));

   assign min_new = (first_ff || (rd_data < min_ff)) ? rd_data : min_ff;

   assign cnt_x = XW'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.operation == mhpq_pkg::OP_INSERT) begin
                  if (cnt_full) begin
                     state_in = mhpq_pkg::ST_DONE;
                  end else if (cnt_zero) begin
                     state_in = mhpq_pkg::ST_PLACE;
                  end else begin
                     state_in = mhpq_pkg::ST_SCAN;
                  end
               end else if (cnt_zero) begin
                  state_in = mhpq_pkg::ST_DONE;
               end else if (req_payload.operation == mhpq_pkg::OP_READ_MIN) begin
                  state_in = mhpq_pkg::ST_MIN;
               end else begin
                  state_in = mhpq_pkg::ST_ROOT;
               end
            end
         end
         mhpq_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = mhpq_pkg::ST_DONE;
            end else if (scan_end) begin
               state_in = mhpq_pkg::ST_UP_CMP;
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            if (!up_move) begin
               state_in = mhpq_pkg::ST_DONE;
            end else if (pos_par == '0) begin
               state_in = mhpq_pkg::ST_PLACE;
            end
         end
         mhpq_pkg::ST_ROOT: begin
            if (op_ff == mhpq_pkg::OP_EXTRACT && !cnt_one) begin
               state_in = mhpq_pkg::ST_EX_LAST;
            end else begin
               state_in = mhpq_pkg::ST_DONE;
            end
         end
         mhpq_pkg::ST_EX_LAST: begin
            state_in = l_ok ? mhpq_pkg::ST_DN_R : mhpq_pkg::ST_PLACE;
         end
         mhpq_pkg::ST_DN_R: begin
            state_in = mhpq_pkg::ST_DN_CMP;
         end
         mhpq_pkg::ST_DN_CMP: begin
            if (!dn_move) begin
               state_in = mhpq_pkg::ST_DONE;
            end else if (big_l_ok) begin
               state_in = mhpq_pkg::ST_DN_R;
            end else begin
               state_in = mhpq_pkg::ST_PLACE;
            end
         end
         mhpq_pkg::ST_MIN: begin
            if (scan_end) begin
               state_in = mhpq_pkg::ST_DONE;
            end
         end
         mhpq_pkg::ST_PLACE: begin
            state_in = mhpq_pkg::ST_DONE;
         end
         mhpq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath, RAM controls and response
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      lval_in      = lval_ff;
      rok_in       = rok_ff;
      first_in     = first_ff;
      min_in       = min_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = val_ff;
      rd_addr      = '0;

      unique case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_payload.operation;
               val_in  = req_payload.value_in;
               res_in  = '0;
               stat_in = mhpq_pkg::STAT_OK;
               if (req_payload.operation == mhpq_pkg::OP_INSERT) begin
                  if (cnt_full) begin
                     stat_in = mhpq_pkg::STAT_FULL;
                  end else if (cnt_zero) begin
                     // first entry goes straight to the root
                     count_in = CW'(1);
                     pos_in   = '0;
                  end else begin
                     rd_addr = '0;
                     ptr_in  = CW'(1);
                  end
               end else if (cnt_zero) begin
                  stat_in = mhpq_pkg::STAT_EMPTY;
               end else if (req_payload.operation == mhpq_pkg::OP_READ_MIN) begin
                  // leaves run from count/2 to count-1
                  rd_addr  = AW'(count_ff >> 1);
                  ptr_in   = CW'((count_ff >> 1) + CW'(1));
                  first_in = 1'b1;
               end else begin
                  rd_addr = '0;
               end
            end
         end
         mhpq_pkg::ST_SCAN: begin
            if (scan_hit) begin
               stat_in = mhpq_pkg::STAT_DUP;
            end else if (scan_end) begin
               // open a hole at the tail and fetch its parent
               count_in = CW'(count_ff + CW'(1));
               pos_in   = count_ff[AW-1:0];
               rd_addr  = cnt_par;
            end else begin
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = CW'(ptr_ff + CW'(1));
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (up_move) begin
               // pull the parent down into the hole, climb one level
               wr_data = rd_data;
               pos_in  = pos_par;
               rd_addr = pos_gpar;
            end
         end
         mhpq_pkg::ST_ROOT: begin
            res_in = rd_data;
            if (op_ff == mhpq_pkg::OP_EXTRACT) begin
               count_in = CW'(count_ff - CW'(1));
               pos_in   = '0;
               rd_addr  = AW'(count_ff - CW'(1));
            end
         end
         mhpq_pkg::ST_EX_LAST: begin
            // old tail becomes the value sinking from the root
            val_in  = rd_data;
            rd_addr = l_idx[AW-1:0];
         end
         mhpq_pkg::ST_DN_R: begin
            lval_in = rd_data;
            rok_in  = r_ok;
            rd_addr = r_idx[AW-1:0];
         end
         mhpq_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (dn_move) begin
               wr_data = big_val;
               pos_in  = big_idx;
               rd_addr = big_l[AW-1:0];
            end
         end
         mhpq_pkg::ST_MIN: begin
            min_in   = min_new;
            first_in = 1'b0;
            if (scan_end) begin
               res_in = min_new;
            end else begin
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = CW'(ptr_ff + CW'(1));
            end
         end
         mhpq_pkg::ST_PLACE: begin
            wr_en = 1'b1;
         end
         mhpq_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.value_out = res_ff;
               rsp_in.status    = stat_ff;
               rsp_in.count     = cnt_x[mhpq_pkg::COUNT_W-1:0];
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      lval_ff  <= lval_in;
      rok_ff   <= rok_in;
      first_ff <= first_in;
      min_ff   <= min_in;
      res_ff   <= res_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

   // count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // every RAM write lands inside the live heap
   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < count_ff))
      else $error("heap write outside live entries");

   // an empty status only ever reports an empty heap
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == mhpq_pkg::STAT_EMPTY) |-> (rsp_ff.count == '0))
      else $error("empty status with entries held");

   // an accepted request always starts work on the next cycle
   a_start_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != mhpq_pkg::ST_IDLE))
      else $error("request accepted but no work started");

endmodule
